// ===== rtl/hdrchk_pkg.sv =====
// Shared types, constants and the CRC table for the header checker.
package hdrchk_pkg;

   // Input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_CRC        = 3'd1;
   localparam logic [2:0] ST_MAGIC      = 3'd2;
   localparam logic [2:0] ST_VERSION    = 3'd3;
   localparam logic [2:0] ST_CONNECTION = 3'd4;
   localparam logic [2:0] ST_REQUEST    = 3'd5;
   localparam logic [2:0] ST_SEQUENCE   = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAGIC      = 2'd0;
   localparam logic [1:0] CSR_VERSION    = 2'd1;
   localparam logic [1:0] CSR_CONNECTION = 2'd2;
   localparam logic [1:0] CSR_REQUEST    = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Header layout
   localparam logic [4:0] CRC_LAST_POS = 5'd28;
   localparam logic [4:0] HDR_LAST_POS = 5'd30;

   // CRC-16/ARC, reflected polynomial
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  sequence_number;
      logic [31:0] payload_length;
      logic [31:0] flag_bits;
      logic [15:0] reserved_word;
      logic [15:0] checksum_word;
   } rsp_type;

   typedef struct packed {
      logic [15:0] magic_value;
      logic [15:0] version_value;
      logic [31:0] connection_value;
      logic [23:0] request_value;
   } cfg_type;

   // One queue entry: a finished header, or a sequence load (value in seq)
   typedef struct packed {
      logic        is_load;
      logic [15:0] crc;
      logic [15:0] checksum;
      logic [15:0] magic;
      logic [15:0] version;
      logic [31:0] connection;
      logic [23:0] request;
      logic [7:0]  seq;
      logic [31:0] payload;
      logic [31:0] flags;
      logic [15:0] reserved;
   } entry_type;

   function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      return {8'h00, crc[15:8]} ^ crc_table_entry(crc[7:0] ^ b);
   endfunction

endpackage

// ===== rtl/protocol_header_checker_top.sv =====
// Top level of the header checker: channels, configuration registers, assertions.
//
// Usage:
//   req channel: one beat per header byte (opcode byte) or a sequence load
//   (opcode load, data_byte = new expected sequence). first_byte restarts
//   the byte count and the CRC. A 31-byte header yields one rsp beat with a
//   status code and the received fields; loads and other bytes yield none.
//   csr port: write csr_wdata into register csr_index when csr_we is high;
//   write only while no header is in flight.
//   Throughput: one req beat per cycle while the queue has room, set by the byte-wide CRC table step.
//   Path to the result: the entry for the last header byte is written into
//   the queue; from the queue head it loads the output register, which
//   drives rsp_valid, once that register is empty or being drained.
//   Reset clears the byte count, CRC, expected sequence, configuration,
//   queue and output valid flag; no clearing pass is needed.
//   When rsp_ready is low, the result holds in the output register; the
//   queue absorbs further headers and req_ready drops only once it is full.
module protocol_header_checker_top #(
   parameter int QUEUE_DEPTH = hdrchk_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hdrchk_pkg::req_type                 req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hdrchk_pkg::rsp_type                 rsp_payload,
   input  logic                                csr_we,
   input  logic [hdrchk_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hdrchk_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hdrchk_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      q_valid;
   entry_type q_head;
   logic      pop;

   // Accept a beat whenever the queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Configuration registers: drop bits above each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:      cfg_in.magic_value      = csr_wdata[15:0];
            CSR_VERSION:    cfg_in.version_value    = csr_wdata[15:0];
            CSR_CONNECTION: cfg_in.connection_value = csr_wdata[31:0];
            CSR_REQUEST:    cfg_in.request_value    = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: byte count, CRC and field capture
   hdrchk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_payload),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue: decouple front from back so each can stall on its own
   hdrchk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   // Back: checks, expected sequence, output register
   hdrchk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (q_valid),
      .head_entry  (q_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // A full queue is never empty
   assert property (@(posedge clock) disable iff (reset) q_full |-> q_valid)
      else $error("queue reports full and empty at once");

   // A new result beat only follows a header entry leaving the queue
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop && !q_head.is_load))
      else $error("result beat without a finished header");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");
`endif

endmodule

// ===== rtl/hdrchk_front.sv =====
// Front part: count header bytes, run the CRC and capture the fields.
module hdrchk_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  hdrchk_pkg::req_type  req,
   output logic                 push,
   output hdrchk_pkg::entry_type push_entry
);
   import hdrchk_pkg::*;

   localparam logic [4:0] MAGIC_POS    = 5'd7;
   localparam logic [4:0] VERSION_POS  = 5'd9;
   localparam logic [4:0] CONN_POS     = 5'd11;
   localparam logic [4:0] REQUEST_POS  = 5'd15;
   localparam logic [4:0] SEQ_POS      = 5'd18;
   localparam logic [4:0] PAYLOAD_POS  = 5'd19;
   localparam logic [4:0] FLAGS_POS    = 5'd23;
   localparam logic [4:0] RESERVED_POS = 5'd27;
   localparam logic [4:0] CHKLOW_POS   = 5'd29;

   logic [4:0]  pos_ff, pos_in, pos_cur;
   logic [15:0] crc_ff, crc_in, crc_cur;
   logic [15:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [31:0] conn_ff, conn_in;
   logic [23:0] request_ff, request_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] payload_ff, payload_in;
   logic [31:0] flags_ff, flags_in;
   logic [15:0] reserved_ff, reserved_in;
   logic [7:0]  chklow_ff, chklow_in;
   logic        is_byte;
   logic [7:0]  b;

   assign is_byte = accept && (req.opcode == OP_BYTE);
   assign b       = req.data_byte;
   assign pos_cur = req.first_byte ? 5'd0 : pos_ff;
   assign crc_cur = req.first_byte ? 16'h0000 : crc_ff;

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      magic_in    = magic_ff;
      version_in  = version_ff;
      conn_in     = conn_ff;
      request_in  = request_ff;
      seq_in      = seq_ff;
      payload_in  = payload_ff;
      flags_in    = flags_ff;
      reserved_in = reserved_ff;
      chklow_in   = chklow_ff;
      if (is_byte) begin
         pos_in = (pos_cur == HDR_LAST_POS) ? 5'd0 : pos_cur + 5'd1;
         crc_in = (pos_cur <= CRC_LAST_POS) ? crc_next(crc_cur, b) : crc_cur;
         unique case (pos_cur)
            MAGIC_POS:           magic_in[7:0]      = b;
            MAGIC_POS + 5'd1:    magic_in[15:8]     = b;
            VERSION_POS:         version_in[7:0]    = b;
            VERSION_POS + 5'd1:  version_in[15:8]   = b;
            CONN_POS:            conn_in[7:0]       = b;
            CONN_POS + 5'd1:     conn_in[15:8]      = b;
            CONN_POS + 5'd2:     conn_in[23:16]     = b;
            CONN_POS + 5'd3:     conn_in[31:24]     = b;
            REQUEST_POS:         request_in[7:0]    = b;
            REQUEST_POS + 5'd1:  request_in[15:8]   = b;
            REQUEST_POS + 5'd2:  request_in[23:16]  = b;
            SEQ_POS:             seq_in             = b;
            PAYLOAD_POS:         payload_in[7:0]    = b;
            PAYLOAD_POS + 5'd1:  payload_in[15:8]   = b;
            PAYLOAD_POS + 5'd2:  payload_in[23:16]  = b;
            PAYLOAD_POS + 5'd3:  payload_in[31:24]  = b;
            FLAGS_POS:           flags_in[7:0]      = b;
            FLAGS_POS + 5'd1:    flags_in[15:8]     = b;
            FLAGS_POS + 5'd2:    flags_in[23:16]    = b;
            FLAGS_POS + 5'd3:    flags_in[31:24]    = b;
            RESERVED_POS:        reserved_in[7:0]   = b;
            RESERVED_POS + 5'd1: reserved_in[15:8]  = b;
            CHKLOW_POS:          chklow_in          = b;
            default: ;
         endcase
      end
   end

   // Push on the last header byte, and on every sequence load
   assign push = accept && ((req.opcode == OP_LOAD) || (pos_cur == HDR_LAST_POS));

   always_comb begin
      push_entry.is_load    = (req.opcode == OP_LOAD);
      push_entry.crc        = crc_cur;
      push_entry.checksum   = {b, chklow_ff};
      push_entry.magic      = magic_ff;
      push_entry.version    = version_ff;
      push_entry.connection = conn_ff;
      push_entry.request    = request_ff;
      push_entry.seq        = (req.opcode == OP_LOAD) ? b : seq_ff;
      push_entry.payload    = payload_ff;
      push_entry.flags      = flags_ff;
      push_entry.reserved   = reserved_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 5'd0;
         crc_ff <= 16'h0000;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      magic_ff    <= magic_in;
      version_ff  <= version_in;
      conn_ff     <= conn_in;
      request_ff  <= request_in;
      seq_ff      <= seq_in;
      payload_ff  <= payload_in;
      flags_ff    <= flags_in;
      reserved_ff <= reserved_in;
      chklow_ff   <= chklow_in;
   end

endmodule

// ===== rtl/hdrchk_queue.sv =====
// Short FIFO of queue entries between the front and back parts.
module hdrchk_queue #(
   parameter int DEPTH = hdrchk_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hdrchk_pkg::entry_type push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output hdrchk_pkg::entry_type head_entry
);
   import hdrchk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/hdrchk_back.sv =====
// Back part: check a finished header against configuration and hold the result.
module hdrchk_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hdrchk_pkg::cfg_type   cfg,
   input  logic                  head_valid,
   input  hdrchk_pkg::entry_type head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hdrchk_pkg::rsp_type   rsp_payload
);
   import hdrchk_pkg::*;

   logic [7:0] expected_ff, expected_in, expected_inc;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] status;
   logic       crc_bad;

   // Loads never need the output slot; headers wait for it to drain
   assign pop = head_valid && (head_entry.is_load || !rsp_valid_ff || rsp_ready);

   assign expected_inc = expected_ff + 8'd1;
   assign crc_bad = (head_entry.checksum != 16'h0000) && (head_entry.crc != head_entry.checksum);

   always_comb begin
      priority if (crc_bad) begin
         status = ST_CRC;
      end else if (head_entry.magic != cfg.magic_value) begin
         status = ST_MAGIC;
      end else if (head_entry.version != cfg.version_value) begin
         status = ST_VERSION;
      end else if (head_entry.connection != cfg.connection_value) begin
         status = ST_CONNECTION;
      end else if (head_entry.request != cfg.request_value) begin
         status = ST_REQUEST;
      end else if (head_entry.seq != expected_inc) begin
         status = ST_SEQUENCE;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      expected_in  = expected_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (pop) begin
         if (head_entry.is_load) begin
            expected_in = head_entry.seq;
         end else begin
            if (status == ST_OK || status == ST_SEQUENCE) begin
               expected_in = expected_inc;
            end
            rsp_valid_in            = 1'b1;
            rsp_in.status           = status;
            rsp_in.sequence_number  = head_entry.seq;
            rsp_in.payload_length   = head_entry.payload;
            rsp_in.flag_bits        = head_entry.flags;
            rsp_in.reserved_word    = head_entry.reserved;
            rsp_in.checksum_word    = head_entry.checksum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         expected_ff  <= expected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/hdrchk_result_monitor.sv =====
// Result monitor for the header checker: predicts each result beat and compares it.
module hdrchk_result_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  hdrchk_pkg::req_type                req_payload,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  hdrchk_pkg::rsp_type                rsp_payload,
   input  logic                               csr_we,
   input  logic [hdrchk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hdrchk_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                 outstanding,
   output int                                 failures
);
   import hdrchk_pkg::*;

   logic [15:0] want_magic, want_version;
   logic [31:0] want_connection;
   logic [23:0] want_request;

   logic [4:0]  byte_pos;
   logic [15:0] crc_acc;
   logic [15:0] rx_magic, rx_version, rx_reserved;
   logic [31:0] rx_connection, rx_payload, rx_flags;
   logic [23:0] rx_request;
   logic [7:0]  rx_sequence, rx_csum_low;
   logic [7:0]  seq_counter;

   rsp_type header_results[$];
   int      mismatch_count = 0;

   assign failures = mismatch_count;

   function automatic logic [15:0] crc16_arc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
      end
   endtask

   // Fold one request beat into the header state; a final byte yields a result.
   task automatic absorb_beat(input req_type beat);
      int          pos;
      logic [15:0] csum, crc_cmp;
      rsp_type     res;
      if (beat.opcode == OP_LOAD) begin
         seq_counter = beat.data_byte;
      end else begin
         if (beat.first_byte) begin
            byte_pos = '0;
            crc_acc  = '0;
         end
         pos = (byte_pos > HDR_LAST_POS) ? 0 : int'(byte_pos);
         if (pos <= CRC_LAST_POS) begin
            crc_acc = crc16_arc_step(crc_acc, beat.data_byte);
         end
         if (pos >= 7 && pos <= 8) begin
            rx_magic[(pos - 7) * 8 +: 8] = beat.data_byte;
         end else if (pos >= 9 && pos <= 10) begin
            rx_version[(pos - 9) * 8 +: 8] = beat.data_byte;
         end else if (pos >= 11 && pos <= 14) begin
            rx_connection[(pos - 11) * 8 +: 8] = beat.data_byte;
         end else if (pos >= 15 && pos <= 17) begin
            rx_request[(pos - 15) * 8 +: 8] = beat.data_byte;
         end else if (pos == 18) begin
            rx_sequence = beat.data_byte;
         end else if (pos >= 19 && pos <= 22) begin
            rx_payload[(pos - 19) * 8 +: 8] = beat.data_byte;
         end else if (pos >= 23 && pos <= 26) begin
            rx_flags[(pos - 23) * 8 +: 8] = beat.data_byte;
         end else if (pos >= 27 && pos <= 28) begin
            rx_reserved[(pos - 27) * 8 +: 8] = beat.data_byte;
         end else if (pos == 29) begin
            rx_csum_low = beat.data_byte;
         end

         if (pos < HDR_LAST_POS) begin
            byte_pos = 5'(pos + 1);
         end else begin
            byte_pos = '0;
            csum     = {beat.data_byte, rx_csum_low};
            // a zero checksum disables the CRC test
            crc_cmp  = (csum != 16'h0000) ? crc_acc : 16'h0000;
            if (crc_cmp != csum) begin
               res.status = ST_CRC;
            end else if (rx_magic != want_magic) begin
               res.status = ST_MAGIC;
            end else if (rx_version != want_version) begin
               res.status = ST_VERSION;
            end else if (rx_connection != want_connection) begin
               res.status = ST_CONNECTION;
            end else if (rx_request != want_request) begin
               res.status = ST_REQUEST;
            end else begin
               seq_counter = seq_counter + 8'd1;
               res.status  = (rx_sequence != seq_counter) ? ST_SEQUENCE : ST_OK;
            end
            res.sequence_number = rx_sequence;
            res.payload_length  = rx_payload;
            res.flag_bits       = rx_flags;
            res.reserved_word   = rx_reserved;
            res.checksum_word   = csum;
            header_results.push_back(res);
         end
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (header_results.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing pending, status %0d", got.status));
      end else begin
         want = header_results.pop_front();
         compare_field("status", got.status, want.status);
         compare_field("sequence_number", got.sequence_number, want.sequence_number);
         compare_field("payload_length", got.payload_length, want.payload_length);
         compare_field("flag_bits", got.flag_bits, want.flag_bits);
         compare_field("reserved_word", got.reserved_word, want.reserved_word);
         compare_field("checksum_word", got.checksum_word, want.checksum_word);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         want_magic      = '0;
         want_version    = '0;
         want_connection = '0;
         want_request    = '0;
         byte_pos        = '0;
         crc_acc         = '0;
         rx_magic        = '0;
         rx_version      = '0;
         rx_connection   = '0;
         rx_request      = '0;
         rx_sequence     = '0;
         rx_payload      = '0;
         rx_flags        = '0;
         rx_reserved     = '0;
         rx_csum_low     = '0;
         seq_counter     = '0;
         header_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAGIC:      want_magic      = csr_wdata[15:0];
               CSR_VERSION:    want_version    = csr_wdata[15:0];
               CSR_CONNECTION: want_connection = csr_wdata[31:0];
               CSR_REQUEST:    want_request    = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
         end
         if (req_valid && req_ready) begin
            absorb_beat(req_payload);
         end
         outstanding <= header_results.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the header checker test: stimulus, receiver, watchdog and verdict.
module testbench;
   import hdrchk_pkg::*;

   localparam int STALL_LIMIT     = 2000;  // cycles with no beat on either channel
   localparam int SETTLE_CYCLES   = 6;     // extra margin after the last result beat
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int BEATS_PER_PHASE = 150;
   localparam int HDR_BYTES       = 31;

   // How a generated header departs from a clean one
   typedef enum {
      HDR_GOOD,
      HDR_BYPASS,
      HDR_BAD_CRC,
      HDR_BAD_MAGIC,
      HDR_BAD_VERSION,
      HDR_BAD_CONNECTION,
      HDR_BAD_REQUEST,
      HDR_BAD_SEQUENCE
   } header_kind_type;

   // Content of the fields that configuration does not constrain
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int outstanding;
   int failures;
   int idle_cycles = 0;
   int beats_sent  = 0;

   // Shadow of the programmed registers, used to build matching headers
   logic [15:0] cfg_magic      = '0;
   logic [15:0] cfg_version    = '0;
   logic [31:0] cfg_connection = '0;
   logic [23:0] cfg_request    = '0;
   // Best guess of the block's expected sequence, so most headers pass
   logic [7:0]  seq_shadow     = '0;

   logic [7:0]  hdr_bytes [HDR_BYTES];
   bit          sender_eager   = 1'b0;
   bit          pressure_burst = 1'b0;
   bit          hold_off_rsp   = 1'b0;
   bit          aligned        = 1'b1;

   protocol_header_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   hdrchk_result_monitor result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: drop ready at random before each result beat, with eager stretches,
   // and hold off for a long stretch when asked so the block backs up.
   initial begin
      int stall;
      bit rsp_eager;
      rsp_eager = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_rsp = 1'b0;
         end
         if ($urandom_range(0, 5) == 0) begin
            rsp_eager = !rsp_eager;
         end
         stall = rsp_eager ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         // ready was high at this edge, so a valid beat is taken here
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic logic [15:0] checksum_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   // Drive one request beat: idle first unless eager, then hold valid until the handshake.
   task automatic send_beat(input logic op, input logic [7:0] data, input logic first);
      int      gap;
      req_type beat;
      gap = sender_eager ? 0 : $urandom_range(0, 5);
      beat.opcode     = op;
      beat.data_byte  = data;
      beat.first_byte = first;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_LOAD) begin
         seq_shadow = data;
      end
      beats_sent++;
   endtask

   function automatic void pick_sender_pace();
      sender_eager = pressure_burst || ($urandom_range(0, 3) == 0);
   endfunction

   // Lay out a 31-byte header in hdr_bytes, matching the shadow registers
   // except for the one departure that the kind asks for.
   function automatic void build_header(input header_kind_type kind, input fill_type fill);
      logic [15:0] magic, version, reserved, crc, csum;
      logic [31:0] connection, payload, flags;
      logic [23:0] request;
      logic [7:0]  seq;
      magic      = cfg_magic;
      version    = cfg_version;
      connection = cfg_connection;
      request    = cfg_request;
      seq        = seq_shadow + 8'd1;
      case (kind)
         HDR_BAD_MAGIC:      magic      = magic ^ 16'($urandom_range(1, 16'hFFFF));
         HDR_BAD_VERSION:    version    = version ^ 16'($urandom_range(1, 16'hFFFF));
         HDR_BAD_CONNECTION: connection = connection ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
         HDR_BAD_REQUEST:    request    = request ^ 24'($urandom_range(1, 24'hFF_FFFF));
         HDR_BAD_SEQUENCE:   seq        = seq + 8'($urandom_range(1, 255));
         default: ;
      endcase
      case (fill)
         FILL_ZERO: begin
            payload  = '0;
            flags    = '0;
            reserved = '0;
         end
         FILL_ONES: begin
            payload  = '1;
            flags    = '1;
            reserved = '1;
         end
         default: begin
            payload  = $urandom();
            flags    = $urandom();
            reserved = 16'($urandom_range(0, 16'hFFFF));
         end
      endcase
      for (int i = 0; i < 7; i++) begin
         hdr_bytes[i] = (fill == FILL_ZERO) ? 8'h00 :
                        (fill == FILL_ONES) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < 2; i++) begin
         hdr_bytes[7 + i]  = magic[8 * i +: 8];
         hdr_bytes[9 + i]  = version[8 * i +: 8];
         hdr_bytes[27 + i] = reserved[8 * i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         hdr_bytes[11 + i] = connection[8 * i +: 8];
         hdr_bytes[19 + i] = payload[8 * i +: 8];
         hdr_bytes[23 + i] = flags[8 * i +: 8];
      end
      for (int i = 0; i < 3; i++) begin
         hdr_bytes[15 + i] = request[8 * i +: 8];
      end
      hdr_bytes[18] = seq;
      crc = '0;
      for (int i = 0; i <= CRC_LAST_POS; i++) begin
         crc = checksum_step(crc, hdr_bytes[i]);
      end
      csum = crc;
      if (kind == HDR_BYPASS) begin
         csum = '0;
      end else if (kind == HDR_BAD_CRC) begin
         // nonzero and wrong, so the CRC test cannot be skipped
         do begin
            csum = 16'($urandom_range(1, 16'hFFFF));
         end while (csum == crc);
      end
      hdr_bytes[29] = csum[7:0];
      hdr_bytes[30] = csum[15:8];
   endfunction

   // Send the first length bytes of a header; optionally slip a sequence load
   // (flagged as a first byte, which a load must ignore) in before byte load_at.
   task automatic send_header(input header_kind_type kind, input fill_type fill,
                              input bit first_mark, input int length, input int load_at);
      build_header(kind, fill);
      pick_sender_pace();
      for (int i = 0; i < length; i++) begin
         if (i == load_at) begin
            send_beat(OP_LOAD, seq_shadow, 1'b1);
         end
         send_beat(OP_BYTE, hdr_bytes[i], (i == 0) ? first_mark : 1'b0);
      end
      // these kinds pass every check ahead of the sequence, so the count advances
      if (length == HDR_BYTES &&
          (kind == HDR_GOOD || kind == HDR_BYPASS || kind == HDR_BAD_SEQUENCE)) begin
         seq_shadow = seq_shadow + 8'd1;
      end
      aligned = (length == HDR_BYTES);
   endtask

   // Drop valid and wait until every result is in and the queue has drained.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program all four registers, one per cycle; junk in the unused upper bits.
   task automatic write_config(input logic [15:0] magic, input logic [15:0] version,
                               input logic [31:0] connection, input logic [23:0] request);
      logic [31:0] junk;
      junk           = $urandom();
      cfg_magic      = magic;
      cfg_version    = version;
      cfg_connection = connection;
      cfg_request    = request;
      csr_we    <= 1'b1;
      csr_index <= CSR_MAGIC;
      csr_wdata <= {junk[31:16], magic};
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= {junk[15:0], version};
      @(posedge clock);
      csr_index <= CSR_CONNECTION;
      csr_wdata <= connection;
      @(posedge clock);
      csr_index <= CSR_REQUEST;
      csr_wdata <= {junk[7:0], request};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Phase 0 programs all zeros, phase 1 mostly all ones; later phases mix extremes in.
   function automatic logic [31:0] pick_value(input int phase);
      int pick;
      pick = $urandom_range(0, 5);
      if (phase == 0 || pick == 0) begin
         return '0;
      end else if (phase == 1 || pick == 1) begin
         return '1;
      end
      return $urandom();
   endfunction

   // One random stimulus item: mostly whole headers, plus loads, truncated
   // headers and raw noise beats that scramble the byte count.
   task automatic random_item();
      int              pick;
      int              count;
      header_kind_type kind;
      pick = $urandom_range(0, 99);
      kind = ($urandom_range(0, 1) == 0) ? HDR_GOOD : header_kind_type'($urandom_range(0, 7));
      if (pick < 60) begin
         send_header(kind, FILL_RANDOM, aligned ? ($urandom_range(0, 7) != 0) : 1'b1,
                     HDR_BYTES, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : -1);
      end else if (pick < 70) begin
         pick_sender_pace();
         send_beat(OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
         send_header(kind, FILL_RANDOM, 1'b1, $urandom_range(1, HDR_BYTES - 1), -1);
      end else begin
         pick_sender_pace();
         count = $urandom_range(1, 8);
         repeat (count) begin
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         end
         aligned = 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: an all-zero header, then a wrap of the sequence
      send_header(HDR_GOOD, FILL_ZERO, 1'b1, HDR_BYTES, -1);
      send_beat(OP_LOAD, 8'hFF, 1'b0);
      send_header(HDR_GOOD, FILL_ONES, 1'b1, HDR_BYTES, -1);

      // Mid-range registers: every header kind once
      settle();
      write_config(16'h5A3C, 16'h0102, 32'h1234_5678, 24'h00AB_CD);
      for (int k = HDR_GOOD; k <= HDR_BAD_SEQUENCE; k++) begin
         send_header(header_kind_type'(k), FILL_RANDOM, 1'b1, HDR_BYTES, -1);
      end
      // no first mark: the count has wrapped to 0, so this still lines up
      send_header(HDR_GOOD, FILL_RANDOM, 1'b0, HDR_BYTES, -1);
      // first mark mid-header drops the partial one; a load inside keeps the count
      send_header(HDR_GOOD, FILL_RANDOM, 1'b1, 12, -1);
      send_header(HDR_GOOD, FILL_RANDOM, 1'b1, HDR_BYTES, 20);

      // All-ones registers and fields
      settle();
      write_config('1, '1, '1, '1);
      send_beat(OP_LOAD, 8'hFE, 1'b0);
      send_header(HDR_GOOD, FILL_ONES, 1'b1, HDR_BYTES, -1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         write_config(16'(pick_value(phase)), 16'(pick_value(phase)),
                      pick_value(phase), 24'(pick_value(phase)));
         if (phase == 2) begin
            // stall the receiver and push headers back to back to fill the queue
            hold_off_rsp   = 1'b1;
            pressure_burst = 1'b1;
            repeat (6) send_header(HDR_GOOD, FILL_RANDOM, 1'b1, HDR_BYTES, -1);
            pressure_burst = 1'b0;
         end
         beats_sent = 0;
         while (beats_sent < BEATS_PER_PHASE) begin
            random_item();
         end
      end

      settle();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
